[sv/ttf_pkg.sv]
// Shared constants and helper functions for the triangle tangent frame pipeline.
package ttf_pkg;

	localparam int NORMAL_FRAC   = 14;
	localparam int UNIT_FRAC     = 14;
	localparam int UNIT_WIDTH    = 16;
	localparam int TAN_PRESCALE  = 24;
	localparam int BIT_PRESCALE  = 20;
	localparam int NORM_PRESCALE = 30;
	localparam int SHIFT_WIDTH   = 7;

	// Number of bits needed to hold x (position of the leading one plus one).
	function automatic logic [SHIFT_WIDTH-1:0] bit_length(input logic [63:0] x);
		logic [SHIFT_WIDTH-1:0] n;
		n = '0;
		for (int i = 0; i < 64; i++) begin
			if (x[i]) begin
				n = SHIFT_WIDTH'(i + 1);
			end
		end
		return n;
	endfunction

	// Smallest right shift that brings the magnitude m below 2^k.
	function automatic logic [SHIFT_WIDTH-1:0] prescale_shift(input logic [63:0] m,
			input logic [SHIFT_WIDTH-1:0] k);
		logic [SHIFT_WIDTH-1:0] bl;
		bl = bit_length(m);
		return (bl > k) ? bl - k : '0;
	endfunction

endpackage

[sv/ttf_tri_if.sv]
// Input channel carrying one triangle word.
interface ttf_tri_if;
	logic        valid;
	logic        ready;
	logic [47:0] pos_first;
	logic [47:0] pos_second;
	logic [47:0] pos_third;
	logic [31:0] uv_first;
	logic [31:0] uv_second;
	logic [31:0] uv_third;
	logic [47:0] normal_first;
	logic        last_in;

	modport source(output valid, pos_first, pos_second, pos_third, uv_first, uv_second,
		uv_third, normal_first, last_in, input ready);
	modport sink(input valid, pos_first, pos_second, pos_third, uv_first, uv_second,
		uv_third, normal_first, last_in, output ready);
endinterface

[sv/ttf_frame_if.sv]
// Output channel carrying one tangent frame word.
interface ttf_frame_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] tangent_x;
	logic signed [15:0] tangent_y;
	logic signed [15:0] tangent_z;
	logic signed [15:0] bitangent_x;
	logic signed [15:0] bitangent_y;
	logic signed [15:0] bitangent_z;
	logic               degenerate;
	logic               last_out;

	modport source(output valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
		bitangent_z, degenerate, last_out, input ready);
	modport sink(input valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
		bitangent_z, degenerate, last_out, output ready);
endinterface

[sv/ttf_norm.sv]
// Pipelined vector normalizer: prescale, sum of squares, square root, divide.
module ttf_norm #(
	parameter int VW = 33,
	parameter int PW = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic signed [VW-1:0]                   vec [3],
	input  logic [PW-1:0]                          pay_in,
	output logic                                   out_valid,
	output logic signed [ttf_pkg::UNIT_WIDTH-1:0]  unit [3],
	output logic [PW-1:0]                          pay_out
);
	import ttf_pkg::*;

	localparam int SVW  = NORM_PRESCALE + 2;
	localparam int MW   = NORM_PRESCALE + 1;
	localparam int SQW  = 2 * NORM_PRESCALE + 2;
	localparam int RW   = NORM_PRESCALE + 1;
	localparam int NUMW = MW + UNIT_FRAC;
	localparam int QW   = UNIT_FRAC + 1;

	logic [VW-1:0] mor;
	always_comb begin
		mor = '0;
		for (int i = 0; i < 3; i++) begin
			mor = mor | (vec[i][VW-1] ? VW'(-vec[i]) : VW'(vec[i]));
		end
	end

	logic                   v_s1, v_s2, v_s3, v_s4;
	logic signed [VW-1:0]   vec_s1 [3];
	logic signed [VW-1:0]   vec_s2 [3];
	logic [VW-1:0]          mor_s1;
	logic [SHIFT_WIDTH-1:0] sh_s2;
	logic signed [SVW-1:0]  vs_s3 [3];
	logic [MW-1:0]          mag_s4 [3];
	logic                   neg_s4 [3];
	logic [SQW-1:0]         sq_s4 [3];
	logic [PW-1:0]          pay_s1, pay_s2, pay_s3, pay_s4;
	logic [MW-1:0]          mg [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mg[i] = vs_s3[i][SVW-1] ? MW'(-vs_s3[i]) : MW'(vs_s3[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mor_s1 <= mor;
			sh_s2  <= prescale_shift(64'(mor_s1), SHIFT_WIDTH'(NORM_PRESCALE));
			pay_s1 <= pay_in;
			pay_s2 <= pay_s1;
			pay_s3 <= pay_s2;
			pay_s4 <= pay_s3;
			for (int i = 0; i < 3; i++) begin
				vec_s1[i] <= vec[i];
				vec_s2[i] <= vec_s1[i];
				vs_s3[i]  <= SVW'(vec_s2[i] >>> sh_s2);
				mag_s4[i] <= mg[i];
				neg_s4[i] <= vs_s3[i][SVW-1];
				sq_s4[i]  <= SQW'(mg[i] * mg[i]);
			end
		end
	end

	// Square root, one result bit per stage.
	logic                 v_r   [0:RW];
	logic [SQW-1:0]       rem_r [0:RW];
	logic [RW-1:0]        root_r[0:RW];
	logic [MW-1:0]        mag_r [0:RW][3];
	logic                 neg_r [0:RW][3];
	logic [PW-1:0]        pay_r [0:RW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r[0] <= 1'b0;
		end else if (en) begin
			v_r[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_r[0]  <= sq_s4[0] + sq_s4[1] + sq_s4[2];
			root_r[0] <= '0;
			mag_r[0]  <= mag_s4;
			neg_r[0]  <= neg_s4;
			pay_r[0]  <= pay_s4;
		end
	end

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		localparam int B = RW - 1 - k;
		logic [SQW:0] trial;
		always_comb begin
			trial = ((SQW+1)'(root_r[k]) << (B + 1)) | ((SQW+1)'(1) << (2 * B));
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_r[k+1] <= 1'b0;
			end else if (en) begin
				v_r[k+1] <= v_r[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_r[k]} >= trial) begin
					rem_r[k+1]  <= rem_r[k] - SQW'(trial);
					root_r[k+1] <= root_r[k] | (RW'(1) << B);
				end else begin
					rem_r[k+1]  <= rem_r[k];
					root_r[k+1] <= root_r[k];
				end
				mag_r[k+1] <= mag_r[k];
				neg_r[k+1] <= neg_r[k];
				pay_r[k+1] <= pay_r[k];
			end
		end
	end

	// Rounded division of each magnitude by the length, one quotient bit per stage.
	logic                 v_d   [0:QW];
	logic [RW-1:0]        len_d [0:QW];
	logic [NUMW-1:0]      rem_d [0:QW][3];
	logic [QW-1:0]        q_d   [0:QW][3];
	logic                 neg_d [0:QW][3];
	logic [PW-1:0]        pay_d [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d[0] <= 1'b0;
		end else if (en) begin
			v_d[0] <= v_r[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_d[0] <= root_r[RW];
			neg_d[0] <= neg_r[RW];
			pay_d[0] <= pay_r[RW];
			for (int i = 0; i < 3; i++) begin
				rem_d[0][i] <= (NUMW'(mag_r[RW][i]) << UNIT_FRAC) + NUMW'(root_r[RW] >> 1);
				q_d[0][i]   <= '0;
			end
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int J = QW - 1 - k;
		logic [NUMW:0] dv;
		always_comb begin
			dv = (NUMW+1)'(len_d[k]) << J;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[k+1] <= 1'b0;
			end else if (en) begin
				v_d[k+1] <= v_d[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if ({1'b0, rem_d[k][i]} >= dv) begin
						rem_d[k+1][i] <= rem_d[k][i] - NUMW'(dv);
						q_d[k+1][i]   <= q_d[k][i] | (QW'(1) << J);
					end else begin
						rem_d[k+1][i] <= rem_d[k][i];
						q_d[k+1][i]   <= q_d[k][i];
					end
				end
				len_d[k+1] <= len_d[k];
				neg_d[k+1] <= neg_d[k];
				pay_d[k+1] <= pay_d[k];
			end
		end
	end

	logic                          v_s6;
	logic signed [UNIT_WIDTH-1:0]  res_s6 [3];
	logic [PW-1:0]                 pay_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_d[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s6 <= pay_d[QW];
			for (int i = 0; i < 3; i++) begin
				if (len_d[QW] == '0) begin
					res_s6[i] <= '0;
				end else if (neg_d[QW][i]) begin
					res_s6[i] <= -UNIT_WIDTH'(q_d[QW][i]);
				end else begin
					res_s6[i] <= UNIT_WIDTH'(q_d[QW][i]);
				end
			end
		end
	end

	assign out_valid = v_s6;
	assign unit      = res_s6;
	assign pay_out   = pay_s6;

endmodule

[sv/triangle_tangent_frame.sv]
// Throughput: one triangle per cycle; a new word enters in every cycle that is not stalled.
// A stall on the output freezes every stage at once, so nothing is dropped or repeated.
// The depth is set by two normalizers, each with a 31-stage square root and 15-stage divider.
// Reset clears only the stage valid bits; data registers take no reset.
module triangle_tangent_frame #(
	parameter int COMPONENT_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	ttf_tri_if.sink            tri_in,
	ttf_frame_if.source        frame_out
);
	import ttf_pkg::*;

	localparam int W    = COMPONENT_WIDTH;
	localparam int XP   = (3 * W > 48) ? 3 * W : 48;
	localparam int XU   = (2 * W > 32) ? 2 * W : 32;
	localparam int DW   = W + 1;              // position and texture deltas
	localparam int PRW  = 2 * DW;             // delta products
	localparam int TW   = PRW + 1;            // raw tangent, bitangent, determinant
	localparam int TSW  = TAN_PRESCALE + 2;   // prescaled tangent
	localparam int BSW  = BIT_PRESCALE + 2;   // prescaled bitangent
	localparam int NTW  = W + TSW;            // normal times tangent
	localparam int DTW  = NTW + 2;            // dot product
	localparam int DSW  = DTW - NORMAL_FRAC;  // dot product after the Q1.14 shift
	localparam int PJW  = DSW + W;            // projection product
	localparam int PSW  = PJW - NORMAL_FRAC;
	localparam int TPW  = ((TSW > PSW) ? TSW : PSW) + 1;
	localparam int CPW  = W + UNIT_WIDTH;     // cross product terms
	localparam int CW   = CPW + 1;            // cross product
	localparam int CBW  = CW + BSW;           // cross times bitangent
	localparam int CSW  = CBW + 2;
	localparam int PW1  = 3 * W + 3 * BSW + 2;
	localparam int PW2  = 3 * UNIT_WIDTH + 2;

	// The whole pipeline advances together; the output register is the last stage.
	logic en;
	assign en = !frame_out.valid || frame_out.ready;
	assign tri_in.ready = en;

	// Component extraction. Components that fall beyond a field read as zero.
	logic [XP-1:0] pf_x, ps_x, pt_x, nf_x;
	logic [XU-1:0] uf_x, us_x, ut_x;
	assign pf_x = XP'(tri_in.pos_first);
	assign ps_x = XP'(tri_in.pos_second);
	assign pt_x = XP'(tri_in.pos_third);
	assign nf_x = XP'(tri_in.normal_first);
	assign uf_x = XU'(tri_in.uv_first);
	assign us_x = XU'(tri_in.uv_second);
	assign ut_x = XU'(tri_in.uv_third);

	logic signed [W-1:0] p0 [3], p1 [3], p2 [3], nn [3];
	logic signed [W-1:0] u0, v0, u1, v1, u2, v2;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p0[i] = signed'(pf_x[i*W +: W]);
			p1[i] = signed'(ps_x[i*W +: W]);
			p2[i] = signed'(pt_x[i*W +: W]);
			nn[i] = signed'(nf_x[i*W +: W]);
		end
		u0 = signed'(uf_x[0 +: W]);
		v0 = signed'(uf_x[W +: W]);
		u1 = signed'(us_x[0 +: W]);
		v1 = signed'(us_x[W +: W]);
		u2 = signed'(ut_x[0 +: W]);
		v2 = signed'(ut_x[W +: W]);
	end

	// Stage valid bits for the front half and the cross-product section.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, v_s14;
	logic n1_valid, n2_valid;

	// Stage 1: edge and texture deltas.
	logic signed [DW-1:0]  d1_s1 [3], d2_s1 [3];
	logic signed [DW-1:0]  du1_s1, dv1_s1, du2_s1, dv2_s1;
	// Stage 2: products of deltas.
	logic signed [PRW-1:0] pda_s2, pdb_s2;
	logic signed [PRW-1:0] pta_s2 [3], ptb_s2 [3], pba_s2 [3], pbb_s2 [3];
	// Stage 3: determinant sign applied to the raw tangent and bitangent.
	logic signed [TW-1:0]  t_s3 [3], b_s3 [3];
	logic                  degen_s3;
	// Stage 4: combined magnitudes for prescaling.
	logic signed [TW-1:0]  t_s4 [3], b_s4 [3];
	logic [TW-1:0]         tor_s4, bor_s4;
	// Stage 5: prescale shift amounts.
	logic signed [TW-1:0]  t_s5 [3], b_s5 [3];
	logic [SHIFT_WIDTH-1:0] st_s5, sb_s5;
	// Stage 6 to 10: orthogonalize the tangent against the normal.
	logic signed [TSW-1:0] tp_s6 [3], tp_s7 [3], tp_s8 [3], tp_s9 [3];
	logic signed [BSW-1:0] bp_s6 [3], bp_s7 [3], bp_s8 [3], bp_s9 [3], bp_s10 [3];
	logic signed [NTW-1:0] ntp_s7 [3];
	logic signed [DSW-1:0] dotsh_s8;
	logic signed [PJW-1:0] proj_s9 [3];
	logic signed [TPW-1:0] tq_s10 [3];

	logic signed [W-1:0]   n_s1 [3], n_s2 [3], n_s3 [3], n_s4 [3], n_s5 [3];
	logic signed [W-1:0]   n_s6 [3], n_s7 [3], n_s8 [3], n_s9 [3], n_s10 [3];
	logic degen_s4, degen_s5, degen_s6, degen_s7, degen_s8, degen_s9, degen_s10;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7, last_s8;
	logic last_s9, last_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
		end else if (en) begin
			v_s1  <= tri_in.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= n1_valid;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
		end
	end

	// Combinational helpers for stages 3, 4 and 8.
	logic                  det_neg;
	logic [TW-1:0]         tor, bor;
	logic signed [DTW-1:0] dot;
	always_comb begin
		det_neg = pda_s2 < pdb_s2;
		tor = '0;
		bor = '0;
		for (int i = 0; i < 3; i++) begin
			tor = tor | (t_s3[i][TW-1] ? TW'(-t_s3[i]) : TW'(t_s3[i]));
			bor = bor | (b_s3[i][TW-1] ? TW'(-b_s3[i]) : TW'(b_s3[i]));
		end
		dot = DTW'(ntp_s7[0]) + DTW'(ntp_s7[1]) + DTW'(ntp_s7[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1
			du1_s1 <= DW'(u1) - DW'(u0);
			dv1_s1 <= DW'(v1) - DW'(v0);
			du2_s1 <= DW'(u2) - DW'(u0);
			dv2_s1 <= DW'(v2) - DW'(v0);
			last_s1 <= tri_in.last_in;
			// Stage 2
			pda_s2 <= PRW'(du1_s1 * dv2_s1);
			pdb_s2 <= PRW'(dv1_s1 * du2_s1);
			last_s2 <= last_s1;
			// Stage 3: dividing by the determinant reduces to taking its sign.
			degen_s3 <= pda_s2 == pdb_s2;
			last_s3  <= last_s2;
			// Stage 4 and 5
			tor_s4 <= tor;
			bor_s4 <= bor;
			degen_s4 <= degen_s3;
			last_s4  <= last_s3;
			st_s5 <= prescale_shift(64'(tor_s4), SHIFT_WIDTH'(TAN_PRESCALE));
			sb_s5 <= prescale_shift(64'(bor_s4), SHIFT_WIDTH'(BIT_PRESCALE));
			degen_s5 <= degen_s4;
			last_s5  <= last_s4;
			degen_s6 <= degen_s5;
			last_s6  <= last_s5;
			degen_s7 <= degen_s6;
			last_s7  <= last_s6;
			// Stage 8: dot product of normal and tangent, back to the tangent scale.
			dotsh_s8 <= DSW'(dot >>> NORMAL_FRAC);
			degen_s8 <= degen_s7;
			last_s8  <= last_s7;
			degen_s9 <= degen_s8;
			last_s9  <= last_s8;
			degen_s10 <= degen_s9;
			last_s10  <= last_s9;
			for (int i = 0; i < 3; i++) begin
				d1_s1[i] <= DW'(p1[i]) - DW'(p0[i]);
				d2_s1[i] <= DW'(p2[i]) - DW'(p0[i]);
				n_s1[i]  <= nn[i];
				pta_s2[i] <= PRW'(d1_s1[i] * dv2_s1);
				ptb_s2[i] <= PRW'(d2_s1[i] * dv1_s1);
				pba_s2[i] <= PRW'(d2_s1[i] * du1_s1);
				pbb_s2[i] <= PRW'(d1_s1[i] * du2_s1);
				n_s2[i] <= n_s1[i];
				if (det_neg) begin
					t_s3[i] <= TW'(ptb_s2[i]) - TW'(pta_s2[i]);
					b_s3[i] <= TW'(pbb_s2[i]) - TW'(pba_s2[i]);
				end else begin
					t_s3[i] <= TW'(pta_s2[i]) - TW'(ptb_s2[i]);
					b_s3[i] <= TW'(pba_s2[i]) - TW'(pbb_s2[i]);
				end
				n_s3[i] <= n_s2[i];
				t_s4[i] <= t_s3[i];
				b_s4[i] <= b_s3[i];
				n_s4[i] <= n_s3[i];
				t_s5[i] <= t_s4[i];
				b_s5[i] <= b_s4[i];
				n_s5[i] <= n_s4[i];
				// Stage 6: floor shifts into the prescaled ranges.
				tp_s6[i] <= TSW'(t_s5[i] >>> st_s5);
				bp_s6[i] <= BSW'(b_s5[i] >>> sb_s5);
				n_s6[i]  <= n_s5[i];
				// Stage 7
				ntp_s7[i] <= NTW'(n_s6[i] * tp_s6[i]);
				tp_s7[i]  <= tp_s6[i];
				bp_s7[i]  <= bp_s6[i];
				n_s7[i]   <= n_s6[i];
				tp_s8[i]  <= tp_s7[i];
				bp_s8[i]  <= bp_s7[i];
				n_s8[i]   <= n_s7[i];
				// Stage 9: projection onto the normal.
				proj_s9[i] <= PJW'(dotsh_s8 * n_s8[i]);
				tp_s9[i]   <= tp_s8[i];
				bp_s9[i]   <= bp_s8[i];
				n_s9[i]    <= n_s8[i];
				// Stage 10: remove the normal part from the tangent.
				tq_s10[i] <= TPW'(tp_s9[i]) - TPW'(proj_s9[i] >>> NORMAL_FRAC);
				bp_s10[i] <= bp_s9[i];
				n_s10[i]  <= n_s9[i];
			end
		end
	end

	// First normalizer: the tangent. The normal, the bitangent and the flags ride along.
	logic [PW1-1:0] pay1_in, pay1_out;
	assign pay1_in = {degen_s10, last_s10,
		bp_s10[2], bp_s10[1], bp_s10[0], n_s10[2], n_s10[1], n_s10[0]};

	logic signed [UNIT_WIDTH-1:0] tn [3];

	ttf_norm #(.VW(TPW), .PW(PW1)) u_tan_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s10),
		.vec       (tq_s10),
		.pay_in    (pay1_in),
		.out_valid (n1_valid),
		.unit      (tn),
		.pay_out   (pay1_out)
	);

	logic signed [W-1:0]   n1 [3];
	logic signed [BSW-1:0] b1 [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n1[i] = signed'(pay1_out[i*W +: W]);
			b1[i] = signed'(pay1_out[3*W + i*BSW +: BSW]);
		end
	end

	// Stages 11 to 14: cross product of normal and tangent, oriented along the bitangent.
	logic signed [CPW-1:0]        cp_s11 [6];
	logic signed [BSW-1:0]        b_s11 [3], b_s12 [3];
	logic signed [UNIT_WIDTH-1:0] tn_s11 [3], tn_s12 [3], tn_s13 [3], tn_s14 [3];
	logic signed [CW-1:0]         c_s12 [3], c_s13 [3], c_s14 [3];
	logic signed [CBW-1:0]        cb_s13 [3];
	logic degen_s11, degen_s12, degen_s13, degen_s14;
	logic last_s11, last_s12, last_s13, last_s14;
	logic signed [CSW-1:0]        cbsum;

	always_comb begin
		cbsum = CSW'(cb_s13[0]) + CSW'(cb_s13[1]) + CSW'(cb_s13[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cp_s11[0] <= CPW'(n1[1] * tn[2]);
			cp_s11[1] <= CPW'(n1[2] * tn[1]);
			cp_s11[2] <= CPW'(n1[2] * tn[0]);
			cp_s11[3] <= CPW'(n1[0] * tn[2]);
			cp_s11[4] <= CPW'(n1[0] * tn[1]);
			cp_s11[5] <= CPW'(n1[1] * tn[0]);
			degen_s11 <= pay1_out[PW1-1];
			last_s11  <= pay1_out[PW1-2];
			degen_s12 <= degen_s11;
			last_s12  <= last_s11;
			degen_s13 <= degen_s12;
			last_s13  <= last_s12;
			degen_s14 <= degen_s13;
			last_s14  <= last_s13;
			for (int i = 0; i < 3; i++) begin
				b_s11[i]  <= b1[i];
				tn_s11[i] <= tn[i];
				c_s12[i]  <= CW'(cp_s11[2*i]) - CW'(cp_s11[2*i+1]);
				b_s12[i]  <= b_s11[i];
				tn_s12[i] <= tn_s11[i];
				cb_s13[i] <= CBW'(c_s12[i] * b_s12[i]);
				c_s13[i]  <= c_s12[i];
				tn_s13[i] <= tn_s12[i];
				c_s14[i]  <= (cbsum < 0) ? -c_s13[i] : c_s13[i];
				tn_s14[i] <= tn_s13[i];
			end
		end
	end

	// Second normalizer: the bitangent. The finished tangent and the flags ride along.
	logic [PW2-1:0] pay2_in, pay2_out;
	assign pay2_in = {degen_s14, last_s14, tn_s14[2], tn_s14[1], tn_s14[0]};

	logic signed [UNIT_WIDTH-1:0] bn [3];

	ttf_norm #(.VW(CW), .PW(PW2)) u_bit_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s14),
		.vec       (c_s14),
		.pay_in    (pay2_in),
		.out_valid (n2_valid),
		.unit      (bn),
		.pay_out   (pay2_out)
	);

	// Output register. A zero determinant forces both vectors to zero.
	logic                          out_valid_q;
	logic signed [UNIT_WIDTH-1:0]  tan_q [3], bit_q [3];
	logic                          degen_q, last_q;
	logic                          degen2;
	assign degen2 = pay2_out[PW2-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= n2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_q <= degen2;
			last_q  <= pay2_out[PW2-2];
			for (int i = 0; i < 3; i++) begin
				tan_q[i] <= degen2 ? '0 : signed'(pay2_out[i*UNIT_WIDTH +: UNIT_WIDTH]);
				bit_q[i] <= degen2 ? '0 : bn[i];
			end
		end
	end

	assign frame_out.valid       = out_valid_q;
	assign frame_out.tangent_x   = tan_q[0];
	assign frame_out.tangent_y   = tan_q[1];
	assign frame_out.tangent_z   = tan_q[2];
	assign frame_out.bitangent_x = bit_q[0];
	assign frame_out.bitangent_y = bit_q[1];
	assign frame_out.bitangent_z = bit_q[2];
	assign frame_out.degenerate  = degen_q;
	assign frame_out.last_out    = last_q;

	// A degenerate triangle must come out with both vectors cleared.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		frame_out.valid && frame_out.degenerate |->
			frame_out.tangent_x == 0 && frame_out.tangent_y == 0 &&
			frame_out.tangent_z == 0 && frame_out.bitangent_x == 0 &&
			frame_out.bitangent_y == 0 && frame_out.bitangent_z == 0)
		else $error("degenerate word carries nonzero vectors");

	// While a finished word waits, the input side must not take a new word.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		frame_out.valid && !frame_out.ready |-> !tri_in.ready)
		else $error("input accepted while output stalled");

	// A stalled output word stays in place for the next cycle.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		frame_out.valid && !frame_out.ready |=> frame_out.valid && $stable(tan_q[0]) &&
			$stable(bit_q[0]) && $stable(last_q))
		else $error("stalled output word changed");

	// The x components of both unit vectors never exceed one in Q1.14.
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_out.valid |-> frame_out.tangent_x <= 16384 && frame_out.tangent_x >= -16384 &&
			frame_out.bitangent_x <= 16384 && frame_out.bitangent_x >= -16384)
		else $error("unit component out of range");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the triangle tangent frame pipeline.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ttf_pkg::*;

	localparam int CW        = 16;
	localparam int WATCHDOG  = 4000;
	localparam int DRAIN     = 300;

	typedef longint vec3_t [3];

	typedef struct {
		logic [47:0] pos_first;
		logic [47:0] pos_second;
		logic [47:0] pos_third;
		logic [31:0] uv_first;
		logic [31:0] uv_second;
		logic [31:0] uv_third;
		logic [47:0] normal_first;
		logic        last_in;
	} triangle_t;

	typedef struct packed {
		logic signed [15:0] tangent_x;
		logic signed [15:0] tangent_y;
		logic signed [15:0] tangent_z;
		logic signed [15:0] bitangent_x;
		logic signed [15:0] bitangent_y;
		logic signed [15:0] bitangent_z;
		logic               degenerate;
		logic               last_out;
	} frame_t;

	logic clk;
	logic arst_n;
	logic calm;

	ttf_tri_if   tri_bus();
	ttf_frame_if frame_bus();

	triangle_tangent_frame #(.COMPONENT_WIDTH(CW)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.tri_in   (tri_bus),
		.frame_out(frame_bus)
	);

	// Frames still owed by the pipeline, oldest first.
	frame_t pending_frames[$];
	int     mismatches;
	int     quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Signed component idx of a packed field.
	function automatic longint field_comp(logic [63:0] f, int idx);
		return longint'($signed(f[idx*CW +: CW]));
	endfunction

	function automatic longint unsigned magnitude(longint x);
		return (x < 0) ? longint'(-x) : x;
	endfunction

	// Shift all three components right by the smallest amount that fits
	// the largest magnitude into k bits. The shift is a floor shift.
	function automatic vec3_t fit_bits(vec3_t v, int k);
		longint unsigned m;
		int s;
		m = 0;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			if (magnitude(v[i]) > m) m = magnitude(v[i]);
		end
		while (s < 62 && (m >> s) >= (64'd1 << k)) s++;
		for (int i = 0; i < 3; i++) v[i] = v[i] >>> s;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Unit vector in Q1.14 with round-to-nearest division; zero stays zero.
	function automatic vec3_t unit_vector(vec3_t v);
		longint unsigned sum;
		longint unsigned len;
		longint unsigned q;
		vec3_t r;
		v = fit_bits(v, NORM_PRESCALE);
		sum = 0;
		for (int i = 0; i < 3; i++) sum += magnitude(v[i]) * magnitude(v[i]);
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			if (len == 0) begin
				r[i] = 0;
			end else begin
				q = ((magnitude(v[i]) << UNIT_FRAC) + (len >> 1)) / len;
				r[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
			end
		end
		return r;
	endfunction

	function automatic frame_t tangent_frame(triangle_t t);
		vec3_t d1, d2, n, tg, bt, tn, c, bn;
		longint du1, dv1, du2, dv2, det, dotp, cb;
		frame_t f;
		for (int i = 0; i < 3; i++) begin
			d1[i] = field_comp(64'(t.pos_second), i) - field_comp(64'(t.pos_first), i);
			d2[i] = field_comp(64'(t.pos_third), i) - field_comp(64'(t.pos_first), i);
			n[i]  = field_comp(64'(t.normal_first), i);
			tn[i] = 0;
			bn[i] = 0;
		end
		du1 = field_comp(64'(t.uv_second), 0) - field_comp(64'(t.uv_first), 0);
		dv1 = field_comp(64'(t.uv_second), 1) - field_comp(64'(t.uv_first), 1);
		du2 = field_comp(64'(t.uv_third), 0) - field_comp(64'(t.uv_first), 0);
		dv2 = field_comp(64'(t.uv_third), 1) - field_comp(64'(t.uv_first), 1);
		det = du1 * dv2 - dv1 * du2;
		if (det != 0) begin
			for (int i = 0; i < 3; i++) begin
				tg[i] = d1[i] * dv2 - d2[i] * dv1;
				bt[i] = d2[i] * du1 - d1[i] * du2;
				if (det < 0) begin
					tg[i] = -tg[i];
					bt[i] = -bt[i];
				end
			end
			tg = fit_bits(tg, TAN_PRESCALE);
			dotp = (n[0] * tg[0] + n[1] * tg[1] + n[2] * tg[2]) >>> NORMAL_FRAC;
			for (int i = 0; i < 3; i++) tg[i] -= (dotp * n[i]) >>> NORMAL_FRAC;
			tn = unit_vector(tg);
			c[0] = n[1] * tn[2] - n[2] * tn[1];
			c[1] = n[2] * tn[0] - n[0] * tn[2];
			c[2] = n[0] * tn[1] - n[1] * tn[0];
			bt = fit_bits(bt, BIT_PRESCALE);
			cb = c[0] * bt[0] + c[1] * bt[1] + c[2] * bt[2];
			if (cb < 0) begin
				for (int i = 0; i < 3; i++) c[i] = -c[i];
			end
			bn = unit_vector(c);
		end
		f.tangent_x   = tn[0][15:0];
		f.tangent_y   = tn[1][15:0];
		f.tangent_z   = tn[2][15:0];
		f.bitangent_x = bn[0][15:0];
		f.bitangent_y = bn[1][15:0];
		f.bitangent_z = bn[2][15:0];
		f.degenerate  = (det == 0);
		f.last_out    = t.last_in;
		return f;
	endfunction

	// Drives one triangle word, optionally after an idle burst, and waits
	// for it to be taken. The expected frame is queued on acceptance.
	task automatic send_triangle(triangle_t t);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			tri_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		tri_bus.pos_first    = t.pos_first;
		tri_bus.pos_second   = t.pos_second;
		tri_bus.pos_third    = t.pos_third;
		tri_bus.uv_first     = t.uv_first;
		tri_bus.uv_second    = t.uv_second;
		tri_bus.uv_third     = t.uv_third;
		tri_bus.normal_first = t.normal_first;
		tri_bus.last_in      = t.last_in;
		tri_bus.valid        = 1'b1;
		do @(posedge clk); while (!tri_bus.ready);
		pending_frames.push_back(tangent_frame(t));
		@(negedge clk);
	endtask

	function automatic logic [47:0] pack3(longint x, longint y, longint z);
		return {z[15:0], y[15:0], x[15:0]};
	endfunction

	function automatic logic [31:0] pack2(longint u, longint v);
		return {v[15:0], u[15:0]};
	endfunction

	function automatic logic [47:0] noise48();
		return 48'({$urandom(), $urandom()});
	endfunction

	// A plausible mesh triangle: small edges, a real texture mapping and a
	// normal of unit length along a random axis or with random components up to 9450 in magnitude.
	function automatic triangle_t mesh_triangle();
		triangle_t t;
		longint bx, by, bz, bu, bv;
		int axis;
		bx = $urandom_range(0, 16000) - 8000;
		by = $urandom_range(0, 16000) - 8000;
		bz = $urandom_range(0, 16000) - 8000;
		bu = $urandom_range(0, 8000) - 4000;
		bv = $urandom_range(0, 8000) - 4000;
		t.pos_first  = pack3(bx, by, bz);
		t.pos_second = pack3(bx + $urandom_range(0, 2000) - 1000,
			by + $urandom_range(0, 2000) - 1000, bz + $urandom_range(0, 2000) - 1000);
		t.pos_third  = pack3(bx + $urandom_range(0, 2000) - 1000,
			by + $urandom_range(0, 2000) - 1000, bz + $urandom_range(0, 2000) - 1000);
		t.uv_first   = pack2(bu, bv);
		t.uv_second  = pack2(bu + $urandom_range(0, 600) - 300, bv + $urandom_range(0, 600) - 300);
		t.uv_third   = pack2(bu + $urandom_range(0, 600) - 300, bv + $urandom_range(0, 600) - 300);
		axis = $urandom_range(0, 3);
		if (axis == 3) begin
			t.normal_first = pack3($urandom_range(0, 18900) - 9450,
				$urandom_range(0, 18900) - 9450, $urandom_range(0, 18900) - 9450);
		end else begin
			t.normal_first = '0;
			t.normal_first[axis*16 +: 16] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
		end
		t.last_in = ($urandom_range(0, 15) == 0);
		return t;
	endfunction

	function automatic triangle_t noise_triangle();
		triangle_t t;
		t.pos_first    = noise48();
		t.pos_second   = noise48();
		t.pos_third    = noise48();
		t.uv_first     = $urandom();
		t.uv_second    = $urandom();
		t.uv_third     = $urandom();
		t.normal_first = noise48();
		t.last_in      = 1'($urandom_range(0, 1));
		return t;
	endfunction

	// Unit square in texture space over an edge along x; the tangent runs along x.
	function automatic triangle_t square_triangle(logic [47:0] normal, logic last);
		triangle_t t;
		t.pos_first    = pack3(0, 0, 0);
		t.pos_second   = pack3(256, 0, 0);
		t.pos_third    = pack3(0, 256, 0);
		t.uv_first     = pack2(0, 0);
		t.uv_second    = pack2(256, 0);
		t.uv_third     = pack2(0, 256);
		t.normal_first = normal;
		t.last_in      = last;
		return t;
	endfunction

	task automatic test_field_extremes();
		triangle_t t;
		t = '{'0, '0, '0, '0, '0, '0, '0, 1'b0};
		send_triangle(t);
		t = '{'1, '1, '1, '1, '1, '1, '1, 1'b1};
		send_triangle(t);
		// Most positive and most negative components on every field.
		t.pos_first    = pack3(-32768, 32767, -32768);
		t.pos_second   = pack3(32767, -32768, 32767);
		t.pos_third    = pack3(-32768, -32768, 32767);
		t.uv_first     = pack2(-32768, -32768);
		t.uv_second    = pack2(32767, -32768);
		t.uv_third     = pack2(-32768, 32767);
		t.normal_first = pack3(32767, -32768, 32767);
		t.last_in      = 1'b0;
		send_triangle(t);
		t.uv_first  = pack2(32767, 32767);
		t.uv_second = pack2(-32768, 32767);
		t.uv_third  = pack2(32767, -32768);
		t.last_in   = 1'b1;
		send_triangle(t);
		t = square_triangle(pack3(-32768, -32768, -32768), 1'b0);
		send_triangle(t);
	endtask

	task automatic test_degenerate_mapping();
		triangle_t t;
		t = square_triangle(pack3(0, 0, 16384), 1'b0);
		t.uv_third = pack2(512, 0);
		send_triangle(t);
		t = mesh_triangle();
		t.uv_second = t.uv_first;
		send_triangle(t);
		t = mesh_triangle();
		t.uv_third = t.uv_second;
		t.last_in  = 1'b1;
		send_triangle(t);
	endtask

	task automatic test_frame_orientation();
		// Normal along the tangent leaves nothing after orthogonalization.
		send_triangle(square_triangle(pack3(16384, 0, 0), 1'b0));
		send_triangle(square_triangle(pack3(-16384, 0, 0), 1'b1));
		// Zero normal gives a zero bitangent.
		send_triangle(square_triangle(pack3(0, 0, 0), 1'b0));
		// Both orientations of the texture mapping and a tilted normal.
		send_triangle(square_triangle(pack3(0, 0, 16384), 1'b0));
		send_triangle(square_triangle(pack3(0, 0, -16384), 1'b0));
		begin
			triangle_t t;
			t = square_triangle(pack3(0, 0, 16384), 1'b1);
			t.uv_third = pack2(0, -256);
			send_triangle(t);
			t = square_triangle(pack3(5000, 3000, 15000), 1'b0);
			send_triangle(t);
			t = square_triangle(pack3(1000, 1000, 1000), 1'b0);
			send_triangle(t);
		end
	endtask

	task automatic test_random_meshes(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 4) == 0) send_triangle(noise_triangle());
			else send_triangle(mesh_triangle());
		end
	endtask

	task automatic test_full_rate(int count);
		calm = 1'b1;
		test_random_meshes(count);
	endtask

	// Output side: random stall bursts until the final stretch.
	initial begin
		frame_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 6) == 0) begin
				frame_bus.ready = 1'b0;
				repeat ($urandom_range(1, 6) - 1) @(negedge clk);
			end else begin
				frame_bus.ready = 1'b1;
			end
		end
	end

	// Each frame word taken is compared with the oldest expectation.
	always @(posedge clk) begin
		frame_t want;
		frame_t got;
		if (arst_n && frame_bus.valid && frame_bus.ready) begin
			got = '{frame_bus.tangent_x, frame_bus.tangent_y, frame_bus.tangent_z,
				frame_bus.bitangent_x, frame_bus.bitangent_y, frame_bus.bitangent_z,
				frame_bus.degenerate, frame_bus.last_out};
			if (pending_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected frame word: %p", got);
			end else begin
				want = pending_frames.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("frame mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((tri_bus.valid && tri_bus.ready) || (frame_bus.valid && frame_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		calm         = 1'b0;
		arst_n       = 1'b0;
		tri_bus.valid        = 1'b0;
		tri_bus.pos_first    = '0;
		tri_bus.pos_second   = '0;
		tri_bus.pos_third    = '0;
		tri_bus.uv_first     = '0;
		tri_bus.uv_second    = '0;
		tri_bus.uv_third     = '0;
		tri_bus.normal_first = '0;
		tri_bus.last_in      = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_field_extremes();
		test_degenerate_mapping();
		test_frame_orientation();
		test_random_meshes(1000);
		test_full_rate(280);

		tri_bus.valid = 1'b0;
		// Drain: the watchdog covers a pipeline that never empties.
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
